### design/smam_pkg.sv
// shared types and constants for the square matrix sum and product engine
package smam_pkg;

  localparam int DEFAULT_MAX_DIM      = 8;
  localparam int DEFAULT_ELEMENT_BITS = 16;

  // result element and coordinate widths
  localparam int VALUE_W    = 35;
  localparam int COORD_W    = 3;
  localparam int OUT_DATA_W = 48;
  localparam int PAD_W      = OUT_DATA_W - VALUE_W - 2 * COORD_W;

  // configuration channel
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_DIM = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OP_MODE    = 4'd1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic {
    MODE_SUM     = 1'b0,
    MODE_PRODUCT = 1'b1
  } op_mode_t;

  localparam op_mode_t MODE_RESET = MODE_PRODUCT;

  // bookkeeping that travels with each operand pair down the pipeline
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               final_cell;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

endpackage

### design/smam_mac.sv
// shared multiply-accumulate unit with the result output register
module smam_mac #(
  parameter int ELEMENT_BITS = smam_pkg::DEFAULT_ELEMENT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [ELEMENT_BITS-1:0]       a_q,
  input  logic signed [ELEMENT_BITS-1:0]       b_q,
  input  smam_pkg::op_mode_t                   op_mode,
  input  smam_pkg::tag_t                       tag_in,
  output logic                                 stall,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // fields from bit 0: result_value[34:0], result_row[37:35], result_col[40:38], zero pad
  output logic [smam_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tlast
);
  import smam_pkg::*;

  localparam int TERM_W = 2 * ELEMENT_BITS;

  logic signed [TERM_W-1:0]  prod;
  logic signed [TERM_W-1:0]  sum_ab;
  logic signed [TERM_W-1:0]  term;
  logic signed [VALUE_W-1:0] term_v;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] acc_sum;
  tag_t                      tag2;
  logic [VALUE_W-1:0]        value_q;
  logic [COORD_W-1:0]        row_q;
  logic [COORD_W-1:0]        col_q;
  logic                      last_q;

  assign stall   = m_tvalid && !m_tready;
  assign prod    = a_q * b_q;
  assign sum_ab  = TERM_W'(a_q) + TERM_W'(b_q);
  // exact term sign-extended to the value width; wider sums wrap to the low bits
  assign term_v  = VALUE_W'(term);
  assign acc_sum = tag2.first ? term_v : acc + term_v;

  always_ff @(posedge clk) begin
    if (!stall) begin
      term <= (op_mode == MODE_PRODUCT) ? prod : sum_ab;
      if (tag2.valid) begin
        acc <= acc_sum;
      end
      if (tag2.valid && tag2.last) begin
        value_q <= acc_sum;
        row_q   <= tag2.row;
        col_q   <= tag2.col;
        last_q  <= tag2.final_cell;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2     <= '0;
      m_tvalid <= 1'b0;
    end else if (!stall) begin
      tag2     <= tag_in;
      m_tvalid <= tag2.valid && tag2.last;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, col_q, row_q, value_q};
  assign m_tlast = last_q;

endmodule

### design/square_matrix_add_multiply.sv
// top level: element loader, matrix stores and multiply-accumulate sequencer
// Elements stream in on s_* one per cycle while idle: dim*dim of A, then dim*dim of B, row-major.
// The transaction that delivers the last B element starts the sequencer, and s_tready
// stays low while it walks the stores through the single multiply-accumulate unit, one
// operand pair per cycle unless stalled: dim^3 pairs for a product and dim^2 for a sum.
// Results leave on m_* in row-major order once the last operand pair of a cell has passed
// the store read, arithmetic and accumulate-into-output-register stages;
// a result not taken on m_* freezes the sequencer and the unit until it is.
// Configuration writes are always taken; matrix_dim 0 acts as 1 and values above
// MAX_DIM act as MAX_DIM.
module square_matrix_add_multiply #(
  parameter int MAX_DIM      = smam_pkg::DEFAULT_MAX_DIM,
  parameter int ELEMENT_BITS = smam_pkg::DEFAULT_ELEMENT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // fields from bit 0: element_value, zero pad to whole bytes
  input  logic [((ELEMENT_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // fields from bit 0: result_value[34:0], result_row[37:35], result_col[40:38], zero pad
  output logic [smam_pkg::OUT_DATA_W-1:0]       m_tdata,
  // last_result
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [smam_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [smam_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import smam_pkg::*;

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CW     = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int LC_W   = $clog2(2 * CELLS + 1);

  typedef enum logic {
    IDLE,
    CALC
  } state_t;

  state_t                   state;
  logic [CFG_DATA_W-1:0]    matrix_dim;
  op_mode_t                 op_mode;
  logic [LC_W-1:0]          load_count;
  logic [IDX_W-1:0]         i;
  logic [IDX_W-1:0]         j;
  logic [IDX_W-1:0]         k;
  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        a_addr;
  logic [ADDR_W-1:0]        b_addr;

  logic signed [ELEMENT_BITS-1:0] mem_a [CELLS];
  logic signed [ELEMENT_BITS-1:0] mem_b [CELLS];
  logic signed [ELEMENT_BITS-1:0] a_q;
  logic signed [ELEMENT_BITS-1:0] b_q;
  logic signed [ELEMENT_BITS-1:0] element;

  logic [CW-1:0]            dim_ext;
  logic [CW-1:0]            d;
  logic [CW-1:0]            d_last;
  logic [2*CW-1:0]          d_sq;
  logic [LC_W-1:0]          area;
  logic [LC_W-1:0]          area2;
  logic [LC_W-1:0]          lc_inc;
  logic [LC_W-1:0]          b_off;
  logic [ADDR_W-1:0]        d_addr;
  logic                     sum_mode;
  logic                     k_end;
  logic                     j_end;
  logic                     i_end;
  logic                     in_accept;
  logic                     stall;
  tag_t                     issue_tag;
  tag_t                     tag1;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign element   = s_tdata[ELEMENT_BITS-1:0];

  // clamp the configured dimension into the supported range
  assign dim_ext = CW'(matrix_dim);
  assign d       = (matrix_dim == '0) ? CW'(1) :
                   (dim_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : dim_ext;
  assign d_last  = d - CW'(1);
  assign d_sq    = d * d;
  assign area    = LC_W'(d_sq);
  assign area2   = area + area;
  assign lc_inc  = load_count + LC_W'(1);
  assign b_off   = load_count - area;
  assign d_addr  = ADDR_W'(d);

  assign sum_mode = (op_mode == MODE_SUM);
  assign k_end    = sum_mode || (CW'(k) == d_last);
  assign j_end    = (CW'(j) == d_last);
  assign i_end    = (CW'(i) == d_last);

  always_comb begin
    issue_tag            = '0;
    issue_tag.valid      = (state == CALC);
    issue_tag.first      = sum_mode || (k == '0);
    issue_tag.last       = k_end;
    issue_tag.final_cell = i_end && j_end;
    issue_tag.row        = COORD_W'(i);
    issue_tag.col        = COORD_W'(j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      matrix_dim <= DIM_RESET;
      op_mode    <= MODE_RESET;
      load_count <= '0;
      i          <= '0;
      j          <= '0;
      k          <= '0;
      row_base   <= '0;
      a_addr     <= '0;
      b_addr     <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MATRIX_DIM: matrix_dim <= cfg_data;
          REG_OP_MODE:    op_mode    <= op_mode_t'(cfg_data[0]);
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (in_accept) begin
            if (lc_inc >= area2) begin
              load_count <= '0;
              state      <= CALC;
              i          <= '0;
              j          <= '0;
              k          <= '0;
              row_base   <= '0;
              a_addr     <= '0;
              b_addr     <= '0;
            end else begin
              load_count <= lc_inc;
            end
          end
        end
        CALC: begin
          if (!stall) begin
            if (!k_end) begin
              k      <= k + IDX_W'(1);
              a_addr <= a_addr + ADDR_W'(1);
              b_addr <= b_addr + d_addr;
            end else begin
              k <= '0;
              if (!j_end) begin
                j      <= j + IDX_W'(1);
                a_addr <= sum_mode ? a_addr + ADDR_W'(1) : row_base;
                b_addr <= sum_mode ? a_addr + ADDR_W'(1) : ADDR_W'(j) + ADDR_W'(1);
              end else begin
                j <= '0;
                if (!i_end) begin
                  i        <= i + IDX_W'(1);
                  row_base <= row_base + d_addr;
                  a_addr   <= row_base + d_addr;
                  b_addr   <= sum_mode ? row_base + d_addr : '0;
                end else begin
                  state <= IDLE;
                end
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A fills first, then B; B positions beyond the matrix are dropped
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (load_count < area) begin
        mem_a[ADDR_W'(load_count)] <= element;
      end else if (b_off < area) begin
        mem_b[ADDR_W'(b_off)] <= element;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      a_q <= mem_a[a_addr];
      b_q <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (!stall) begin
      tag1 <= issue_tag;
    end
  end

  smam_mac #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .a_q     (a_q),
    .b_q     (b_q),
    .op_mode (op_mode),
    .tag_in  (tag1),
    .stall   (stall),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

`ifndef SYNTHESIS
  // sequencer counters stay inside the active matrix
  assert property (@(posedge clk) disable iff (rst)
    (state == CALC) |-> (CW'(i) < d) && (CW'(j) < d) && (CW'(k) < d))
    else $error("sequencer index outside the matrix");

  // the load counter is cleared whenever a pass starts
  assert property (@(posedge clk) disable iff (rst)
    $rose(state == CALC) |-> (load_count == '0))
    else $error("load count not cleared at start of pass");

  // an operand pair in the read stage was issued by the sequencer or held by a stall
  assert property (@(posedge clk) disable iff (rst)
    (tag1.valid && !$past(stall)) |-> $past(state == CALC))
    else $error("operand pair without an issue");

  // the final result element sits on the diagonal
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |->
      (m_tdata[VALUE_W +: COORD_W] == m_tdata[VALUE_W + COORD_W +: COORD_W]))
    else $error("final result element off the diagonal");
`endif

endmodule

### sim/tb_top.sv
// testbench for the square matrix sum and product engine: directed table, random passes, scoreboard
`timescale 1ns / 100ps

module tb_top;
  import smam_pkg::*;

  localparam int MAX_DIM         = DEFAULT_MAX_DIM;
  localparam int ELEM_W          = DEFAULT_ELEMENT_BITS;
  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 16;   // pipeline tail after the last result
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER  = 2;    // elements accepted before the long hold-off
  localparam int RANDOM_ITEMS    = 16;
  localparam int IDLE_PCT        = 35;
  // slowest stretch is the hold-off plus a few dim-8 cells, well under this
  localparam int STALL_LIMIT     = 5000;

  // indexes past the register list, writes there are dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 4'd15;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [ELEM_W-1:0]      s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic                      last;
  } cell_t;

  typedef struct {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [ELEM_W-1:0]      element;
    logic                   typed;
    longint                 typed_value;
  } plan_row_t;

  cell_t expected_cells[$];

  // mirror of the engine state
  logic signed [ELEM_W-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] mat_b [MAX_DIM*MAX_DIM];
  int unsigned              fill_count = 0;
  logic [CFG_DATA_W-1:0]    dim_reg    = DIM_RESET;
  op_mode_t                 mode_reg   = MODE_RESET;

  int  errors          = 0;
  int  results_checked = 0;
  int  elements_taken  = 0;
  int  reg_writes      = 0;
  int  stall_cycles    = 0;
  bit  calm            = 1'b0;

  square_matrix_add_multiply u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int effective_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return int'(dim_reg);
  endfunction

  // load one element and queue the result matrix when B is complete
  task automatic predict_matrix(input logic signed [ELEM_W-1:0] x);
    int     d;
    int     area;
    longint acc;
    cell_t  c;
    d    = effective_dim();
    area = d * d;
    if (fill_count < area) begin
      mat_a[fill_count] = x;
    end else if (fill_count - area < area) begin
      mat_b[fill_count - area] = x;
    end
    fill_count++;
    if (fill_count >= 2 * area) begin
      for (int i = 0; i < d; i++) begin
        for (int j = 0; j < d; j++) begin
          if (mode_reg == MODE_SUM) begin
            acc = longint'(mat_a[i*d+j]) + longint'(mat_b[i*d+j]);
          end else begin
            acc = 0;
            for (int k = 0; k < d; k++) begin
              acc += longint'(mat_a[i*d+k]) * longint'(mat_b[k*d+j]);
            end
          end
          c.value = acc[VALUE_W-1:0];
          c.row   = COORD_W'(i);
          c.col   = COORD_W'(j);
          c.last  = (i == d - 1) && (j == d - 1);
          expected_cells = {expected_cells, c};
        end
      end
      fill_count = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at %0t: %0s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return ELEM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{1'b1, index, data, '0, 1'b0, 0};
    return r;
  endfunction

  function automatic plan_row_t elem_row(input logic [ELEM_W-1:0] element,
                                         input logic typed, input longint want);
    plan_row_t r;
    r = '{1'b0, '0, '0, element, typed, want};
    return r;
  endfunction

  task automatic send_element(input logic [ELEM_W-1:0] x);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    elements_taken++;
    predict_matrix(x);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (index == REG_MATRIX_DIM) begin
      dim_reg = data;
    end else if (index == REG_OP_MODE) begin
      mode_reg = op_mode_t'(data[0]);
    end
    @(posedge clk);
  endtask

  // quiet the input, collect every pending cell, let the pipeline drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin : result_sink
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && elements_taken >= HOLD_OFF_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_cells
    cell_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("result with nothing pending", $signed(m_tdata[VALUE_W-1:0]), 0);
      end else begin
        want = expected_cells.pop_front();
        results_checked++;
        if (m_tdata[VALUE_W-1:0] !== want.value)
          report_mismatch("value", $signed(m_tdata[VALUE_W-1:0]), want.value);
        if (m_tdata[VALUE_W+COORD_W-1:VALUE_W] !== want.row)
          report_mismatch("row", m_tdata[VALUE_W+COORD_W-1:VALUE_W], want.row);
        if (m_tdata[VALUE_W+2*COORD_W-1:VALUE_W+COORD_W] !== want.col)
          report_mismatch("col", m_tdata[VALUE_W+2*COORD_W-1:VALUE_W+COORD_W], want.col);
        if (m_tlast !== want.last)
          report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    int        n_random;
    int        dim_now;
    int        partial;
    int        passes;

    n_random = 0;
    foreach (mat_a[i]) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 1x1 products at the element extremes
    plan = {plan, cfg_row(REG_MATRIX_DIM, 4'd1)};
    plan = {plan, elem_row(16'h7fff, 1'b0, 0)};
    plan = {plan, elem_row(16'h7fff, 1'b1, 64'sd1073676289)};
    plan = {plan, elem_row(16'h8000, 1'b0, 0)};
    plan = {plan, elem_row(16'h8000, 1'b1, 64'sd1073741824)};
    plan = {plan, elem_row(16'h8000, 1'b0, 0)};
    plan = {plan, elem_row(16'h7fff, 1'b1, -64'sd1073709056)};
    // sum mode, upper data bits set and ignored
    plan = {plan, cfg_row(REG_OP_MODE, {3'b111, MODE_SUM})};
    plan = {plan, elem_row(16'h7fff, 1'b0, 0)};
    plan = {plan, elem_row(16'h7fff, 1'b1, 64'sd65534)};
    plan = {plan, elem_row(16'h8000, 1'b0, 0)};
    plan = {plan, elem_row(16'h8000, 1'b1, -64'sd65536)};
    // dimension zero behaves as one
    plan = {plan, cfg_row(REG_MATRIX_DIM, 4'd0)};
    plan = {plan, elem_row(16'd5, 1'b0, 0)};
    plan = {plan, elem_row(-16'sd7, 1'b1, -64'sd2)};
    plan = {plan, cfg_row(REG_SPARE_LOW, 4'hA)};
    plan = {plan, cfg_row(REG_SPARE_HIGH, 4'h5)};
    // shrink mid-load: the pass ends on the next element
    plan = {plan, cfg_row(REG_MATRIX_DIM, 4'd2)};
    plan = {plan, cfg_row(REG_OP_MODE, {3'b000, MODE_PRODUCT})};
    plan = {plan, elem_row(16'd1, 1'b0, 0)};
    plan = {plan, elem_row(16'd2, 1'b0, 0)};
    plan = {plan, elem_row(16'd3, 1'b0, 0)};
    plan = {plan, cfg_row(REG_MATRIX_DIM, 4'd1)};
    plan = {plan, elem_row(16'd9, 1'b0, 0)};
    // grow mid-load from one to two
    plan = {plan, elem_row(16'd4, 1'b0, 0)};
    plan = {plan, cfg_row(REG_MATRIX_DIM, 4'd2)};
    plan = {plan, elem_row(-16'sd3, 1'b0, 0)};
    plan = {plan, elem_row(16'd100, 1'b0, 0)};
    plan = {plan, elem_row(16'h8000, 1'b0, 0)};
    plan = {plan, elem_row(16'h7fff, 1'b0, 0)};
    plan = {plan, elem_row(16'd7, 1'b0, 0)};
    plan = {plan, elem_row(16'hffff, 1'b0, 0)};
    plan = {plan, elem_row(16'd0, 1'b0, 0)};

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        write_register(plan[r].index, plan[r].data);
      end else begin
        send_element(plan[r].element);
        if (plan[r].typed) expected_cells[$].value = plan[r].typed_value[VALUE_W-1:0];
      end
    end

    while (n_random < RANDOM_ITEMS) begin
      settle();
      write_register(REG_MATRIX_DIM, 4'($urandom_range(0, 3)));
      write_register(REG_OP_MODE, 4'($urandom_range(0, 15)));
      if ($urandom_range(0, 3) == 0)
        write_register(4'($urandom_range(REG_SPARE_HIGH, REG_SPARE_LOW)),
                       4'($urandom_range(0, 15)));
      dim_now = effective_dim();
      if (dim_now >= 2 && $urandom_range(0, 4) == 0) begin
        // broken pass: cut short by dropping to one, only a[0] and b[0] get read
        partial = $urandom_range(1, 2 * dim_now * dim_now - 1);
        repeat (partial) send_element(rand_element());
        settle();
        write_register(REG_MATRIX_DIM, 4'($urandom_range(0, 1)));
        send_element(rand_element());
        n_random += partial + 1;
      end else begin
        passes = $urandom_range(1, 2);
        repeat (passes * 2 * dim_now * dim_now) send_element(rand_element());
        n_random += passes * 2 * dim_now * dim_now;
      end
    end

    // one pass at the largest size, oversized register value, heavy on the most negative
    // element, with no idling on either side
    settle();
    calm = 1'b1;
    write_register(REG_MATRIX_DIM, 4'hF);
    write_register(REG_OP_MODE, {3'b000, MODE_PRODUCT});
    repeat (2 * MAX_DIM * MAX_DIM)
      send_element(($urandom_range(0, 1) == 0) ? 16'h8000 : rand_element());
    settle();
    calm = 1'b0;

    $display("run covered %0d elements, %0d result cells, %0d register writes",
             elements_taken, results_checked, reg_writes);
    $display("dims 0 to 3 and 15, sum and product, mid-load resize, long result hold-off");
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### square_matrix_add_multiply.f
design/smam_pkg.sv
design/smam_mac.sv
design/square_matrix_add_multiply.sv
sim/tb_top.sv
